// ===== hdl/bcp_pkg.sv =====
// Shared constants and types of the Pascal-row binomial coefficient core.
package bcp_pkg;

    // Largest row of the triangle that the row store holds.
    localparam int MAX_N   = 63;
    localparam int ENTRIES = MAX_N + 1;
    localparam int COEF_W  = 60;
    localparam int IDX_W   = 6;
    localparam int BIT_W   = $clog2(IDX_W);

    typedef logic [COEF_W-1:0]                t_coef;
    typedef logic [ENTRIES-1:0][COEF_W-1:0]   t_row;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;
        logic             step;
        logic             shift;
        logic [BIT_W-1:0] shift_bit;
        logic [IDX_W-1:0] k;
        logic             out_load;
        logic             oor;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// ===== hdl/bcp_datapath.sv =====
// Row store of adder cells, alignment shifter and output register.
module bcp_datapath import bcp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    output t_status o_status,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_coef   o_coefficient
);

    t_row  r_row;
    t_row  n_row;
    t_coef r_coef;
    logic  r_out_valid;

    // Next row: reload, one triangle row of additions, or one shift stage.
    always_comb begin
        n_row = r_row;
        if (i_cmd.load) begin
            n_row    = '0;
            n_row[0] = t_coef'(1);
        end else if (i_cmd.step) begin
            // Every cell up to column k adds its left neighbor in parallel.
            for (int j = 1; j < ENTRIES; j++) begin
                if ((IDX_W+1)'(j) <= {1'b0, i_cmd.k}) begin
                    n_row[j] = r_row[j] + r_row[j-1];
                end
            end
        end else if (i_cmd.shift) begin
            // Move column k toward entry 0, one bit of k per cycle.
            for (int b = 0; b < IDX_W; b++) begin
                if (i_cmd.shift_bit == BIT_W'(b) && i_cmd.k[b]) begin
                    n_row = r_row >> (COEF_W << b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
    end

    // Output register holds the result until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_coef <= i_cmd.oor ? '0 : r_row[0];
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_coefficient     = r_coef;

endmodule

// ===== hdl/bcp_controller.sv =====
// Sequencer that steps the row store through the rows and emits the result.
module bcp_controller import bcp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [IDX_W-1:0] i_n,
    input  logic [IDX_W-1:0] i_k,
    output t_cmd             o_cmd,
    input  t_status          i_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROWS,
        S_SHIFT,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_n;
    logic [IDX_W-1:0] r_k;
    logic [IDX_W-1:0] r_cnt;
    logic [BIT_W-1:0] r_bit;
    logic             r_oor;
    logic             w_accept;

    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign w_accept   = i_in_valid && !o_in_stall;

    // State, row counter and shift stage counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_bit   <= '0;
            r_oor   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_n   <= i_n;
                        r_k   <= i_k;
                        r_cnt <= IDX_W'(1);
                        r_bit <= '0;
                        r_oor <= (i_n > IDX_W'(MAX_N));
                        if (i_n == '0 || i_n > IDX_W'(MAX_N)) begin
                            r_state <= S_SHIFT;
                        end else begin
                            r_state <= S_ROWS;
                        end
                    end
                end
                S_ROWS: begin
                    if (r_cnt == r_n) begin
                        r_state <= S_SHIFT;
                    end else begin
                        r_cnt <= r_cnt + IDX_W'(1);
                    end
                end
                S_SHIFT: begin
                    if (r_bit == BIT_W'(IDX_W - 1)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_bit <= r_bit + BIT_W'(1);
                    end
                end
                S_EMIT: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath commands follow from the state.
    always_comb begin
        o_cmd           = '0;
        o_cmd.k         = r_k;
        o_cmd.shift_bit = r_bit;
        o_cmd.oor       = r_oor;
        o_cmd.load      = w_accept;
        o_cmd.step      = (r_state == S_ROWS);
        o_cmd.shift     = (r_state == S_SHIFT);
        o_cmd.out_load  = (r_state == S_EMIT) && i_status.out_free;
    end

endmodule

// ===== hdl/binomial_coefficient_pascal_row_core.sv =====
// Top level of the Pascal-row binomial coefficient core.
//
// Each request carries n and k on i_n and i_k and returns C(n,k) on
// o_coefficient, or zero when k exceeds n. Both channels use valid and
// stall: a request is taken at a clock edge where i_in_valid is high and
// o_in_stall is low, a result where o_out_valid is high and i_out_stall low.
// A request reloads a row of adder cells with 1,0,0,...; each following
// cycle adds one triangle row to cells 1 to k at once, n rows in all.
// The shifter then moves column k down to entry 0, one bit of k per
// cycle, and the output register is loaded with the result. The core
// takes no new request until its result is in the output register.
// The output register lets the next request run while a result waits; a
// stalled receiver holds the core only when a second result is ready to
// be written. Reset is synchronous and active low; it empties the output
// register and returns the sequencer to idle, and o_in_stall stays high
// while reset is applied.
module binomial_coefficient_pascal_row_core import bcp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [IDX_W-1:0] i_n,
    input  logic [IDX_W-1:0] i_k,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_coef            o_coefficient
);

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer.
    bcp_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_n        (i_n),
        .i_k        (i_k),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    // Row store and output register.
    bcp_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_coefficient (o_coefficient)
    );

endmodule

// ===== hdl/bcp_checker.sv =====
// Port-level checks of the binomial coefficient core and their binding.
module bcp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [59:0] o_coefficient
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_coef_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_coefficient))
        else $error("result changed while stalled");

    // The core works on one request at a time.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while busy");

    // No result appears in the cycle after a request is taken.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !(o_out_valid && i_out_stall) |=> !o_out_valid)
        else $error("result too early");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind binomial_coefficient_pascal_row_core bcp_checker u_chk (.*);
